@@ rtl/bhdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhdp_pkg
// Shared types and constants for the baseline heading / dip pairing block.
// ----------------------------------------------------------------------------
package bhdp_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ATAN_LEN     = 40;
   localparam int CORDIC_USED  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_USED - 1);

   localparam logic [2:0]  FIX_INVALID  = 3'd0;
   localparam logic [2:0]  FIX_RTK      = 3'd4;
   localparam logic [1:0]  REG_PAIR     = 2'd0;
   localparam logic [1:0]  REG_HEAD_OFS = 2'd1;
   localparam logic [1:0]  REG_DIP_OFS  = 2'd2;
   localparam logic [32:0] GAIN_Q28     = 33'sd442048841;
   localparam logic [32:0] CENTI_TURN   = 33'sd36000;
   localparam logic        MODE_TIME    = 1'b0;

   typedef enum logic [3:0] {
      S_IDLE, S_MN, S_ME, S_MD, S_MG, S_SQH, S_RNDH, S_SQF, S_RNDF,
      S_CINIT, S_CITER, S_CONV, S_CFIN, S_EMIT
   } state_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [31:0] turn_atan(input logic [5:0] i);
      logic [31:0] v;
      unique case (i)
         6'd0:  v = 32'd536870912;
         6'd1:  v = 32'd316933406;
         6'd2:  v = 32'd167458907;
         6'd3:  v = 32'd85004756;
         6'd4:  v = 32'd42667331;
         6'd5:  v = 32'd21354465;
         6'd6:  v = 32'd10679838;
         6'd7:  v = 32'd5340245;
         6'd8:  v = 32'd2670163;
         6'd9:  v = 32'd1335087;
         6'd10: v = 32'd667544;
         6'd11: v = 32'd333772;
         6'd12: v = 32'd166886;
         6'd13: v = 32'd83443;
         6'd14: v = 32'd41722;
         6'd15: v = 32'd20861;
         6'd16: v = 32'd10430;
         6'd17: v = 32'd5215;
         6'd18: v = 32'd2608;
         6'd19: v = 32'd1304;
         6'd20: v = 32'd652;
         6'd21: v = 32'd326;
         6'd22: v = 32'd163;
         6'd23: v = 32'd81;
         6'd24: v = 32'd41;
         6'd25: v = 32'd20;
         6'd26: v = 32'd10;
         6'd27: v = 32'd5;
         6'd28: v = 32'd3;
         6'd29: v = 32'd1;
         6'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/baseline_heading_dip_pairing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baseline_heading_dip_pairing
// Baseline lengths, heading and dip from NED baselines, paired with time stamps.
// ----------------------------------------------------------------------------
// Flow: a time item (dropped if pairing is off) or an invalid-fix baseline goes
//   straight to the emit state; a valid fix first takes both square roots, and
//   a fixed-RTK fix then both CORDIC passes. One item at a time; the shared 33x33
//   multiplier, the bit-pair square root and the 64-bit CORDIC iteration are reused.
// Reset (synchronous, high): record and stamps clear, pairing on, offsets 0.
module baseline_heading_dip_pairing
   import bhdp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // week_ms, fix_kind, sat_count, north_mm, east_mm, down_mm,
   // horiz_acc_mm, vert_acc_mm (low bit up), zero pad to 176
   input  logic [175:0] req_tdata,
   // mode: 0 time item, 1 baseline item
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_fix_kind, out_sats, out_north, out_east, out_down, out_horiz_err,
   // out_vert_err, length_mm, horiz_length_mm, heading, dip,
   // orientation_ok (low bit up), zero pad to 240
   output logic [239:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [16:0]  csr_data
);

   // input field views
   logic        [29:0] in_week;
   logic        [2:0]  in_fix;
   logic        [7:0]  in_sats;
   logic signed [31:0] in_n, in_e, in_d;
   logic        [15:0] in_hacc, in_vacc;
   assign in_week = req_tdata[29:0];
   assign in_fix  = req_tdata[32:30];
   assign in_sats = req_tdata[40:33];
   assign in_n    = req_tdata[72:41];
   assign in_e    = req_tdata[104:73];
   assign in_d    = req_tdata[136:105];
   assign in_hacc = req_tdata[152:137];
   assign in_vacc = req_tdata[168:153];

   // control and record state
   state_type state_ff, state_in;
   logic               pair_ff, pair_in;
   logic signed [16:0] hofs_ff, hofs_in;
   logic signed [15:0] dofs_ff, dofs_in;
   logic               tv_ff, tv_in, bv_ff, bv_in;
   logic        [29:0] tval_ff, tval_in, bval_ff, bval_in;
   logic        [2:0]  rfix_ff, rfix_in;
   logic        [7:0]  rsats_ff, rsats_in;
   logic signed [31:0] rn_ff, rn_in, re_ff, re_in, rd_ff, rd_in;
   logic        [15:0] rherr_ff, rherr_in, rverr_ff, rverr_in;
   logic        [31:0] rlen_ff, rlen_in, rhlen_ff, rhlen_in;
   logic        [15:0] rhead_ff, rhead_in;
   logic signed [15:0] rdip_ff, rdip_in;
   logic               rok_ff, rok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic        [239:0] rsp_data_ff, rsp_data_in;

   // datapath work registers
   logic signed [65:0] prod_ff, prod_in;
   logic        [63:0] sum_ff, sum_in, full_ff, full_in;
   logic        [63:0] rest_ff, rest_in, root_ff, root_in, bit_ff, bit_in;
   logic signed [63:0] yd_ff, yd_in;
   logic signed [63:0] cx_ff, cx_in, cy_ff, cy_in;
   logic        [31:0] cz_ff, cz_in;
   logic        [5:0]  step_ff, step_in;
   logic               pass_ff, pass_in;

   // shared multiplier operands
   logic signed [32:0] mul_a, mul_b;
   logic               mul_en;

   // combinational helpers
   logic        [64:0] trial;
   logic        [63:0] sq_root_nx, sq_rest_nx;
   logic signed [63:0] ld_x, ld_y, sh_x, sh_y;
   logic        [65:0] rnd;
   logic        [15:0] h_raw;
   logic signed [18:0] h_sum;
   logic signed [15:0] d_raw;
   logic signed [17:0] d_sum;
   logic               match;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one square-root step: one result bit per pass, the trial bit moving down two places
   always_comb begin
      trial = {1'b0, root_ff} + {1'b0, bit_ff};
      if ({1'b0, rest_ff} >= trial) begin
         sq_rest_nx = rest_ff - trial[63:0];
         sq_root_nx = (root_ff >> 1) + bit_ff;
      end else begin
         sq_rest_nx = rest_ff;
         sq_root_nx = root_ff >> 1;
      end
   end

   // CORDIC load values and shifted terms
   always_comb begin
      if (pass_ff) begin
         ld_x = cx_ff;
         ld_y = yd_ff;
      end else begin
         ld_x = {{4{rn_ff[31]}}, rn_ff, 28'd0};
         ld_y = {{4{re_ff[31]}}, re_ff, 28'd0};
      end
      sh_x = cx_ff >>> step_ff;
      sh_y = cy_ff >>> step_ff;
   end

   // angle conversion: round(z * 36000 / 2^32), then offsets
   always_comb begin
      rnd   = prod_ff + 66'sh80000000;
      h_raw = rnd[47:32];
      if (h_raw >= 16'd36000) h_raw = 16'd0;
      h_sum = 19'(signed'({1'b0, h_raw})) + 19'(hofs_ff);
      priority if (h_sum < -19'sd36000)      h_sum = h_sum + 19'sd72000;
      else if (h_sum < 19'sd0)              h_sum = h_sum + 19'sd36000;
      else if (h_sum >= 19'sd72000)         h_sum = h_sum - 19'sd72000;
      else if (h_sum >= 19'sd36000)         h_sum = h_sum - 19'sd36000;
      d_raw = signed'(rnd[47:32]);
      d_sum = 18'(d_raw) + 18'(dofs_ff);
      if (d_sum > 18'sd27000)  d_sum = 18'sd27000;
      if (d_sum < -18'sd27000) d_sum = -18'sd27000;
   end

   assign match = !pair_ff || (tv_ff && bv_ff && (tval_ff == bval_ff));

   // sequencer
   always_comb begin
      state_in = state_ff;
      pair_in = pair_ff; hofs_in = hofs_ff; dofs_in = dofs_ff;
      tv_in = tv_ff; bv_in = bv_ff; tval_in = tval_ff; bval_in = bval_ff;
      rfix_in = rfix_ff; rsats_in = rsats_ff;
      rn_in = rn_ff; re_in = re_ff; rd_in = rd_ff;
      rherr_in = rherr_ff; rverr_in = rverr_ff;
      rlen_in = rlen_ff; rhlen_in = rhlen_ff;
      rhead_in = rhead_ff; rdip_in = rdip_ff; rok_in = rok_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      sum_in = sum_ff; full_in = full_ff;
      rest_in = rest_ff; root_in = root_ff; bit_in = bit_ff;
      yd_in = yd_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      step_in = step_ff; pass_in = pass_ff;
      mul_en = 1'b0; mul_a = '0; mul_b = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            REG_PAIR:     pair_in = csr_data[0];
            REG_HEAD_OFS: hofs_in = signed'(csr_data);
            REG_DIP_OFS:  dofs_in = signed'(csr_data[15:0]);
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == MODE_TIME) begin
                  // time items are dropped when pairing is off
                  if (pair_ff) begin
                     tv_in = 1'b1;
                     tval_in = in_week;
                     state_in = S_EMIT;
                  end
               end else begin
                  rfix_in = in_fix;
                  bv_in = 1'b1;
                  bval_in = in_week;
                  if (in_fix != FIX_INVALID) begin
                     rsats_in = in_sats;
                     rn_in = in_n; re_in = in_e; rd_in = in_d;
                     rherr_in = in_hacc; rverr_in = in_vacc;
                     state_in = S_MN;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_MN: begin
            mul_en = 1'b1; mul_a = 33'(rn_ff); mul_b = 33'(rn_ff);
            state_in = S_ME;
         end
         S_ME: begin
            sum_in = prod_ff[63:0];
            mul_en = 1'b1; mul_a = 33'(re_ff); mul_b = 33'(re_ff);
            state_in = S_MD;
         end
         S_MD: begin
            sum_in = sum_ff + prod_ff[63:0];
            mul_en = 1'b1; mul_a = 33'(rd_ff); mul_b = 33'(rd_ff);
            state_in = S_MG;
         end
         S_MG: begin
            full_in = sum_ff + prod_ff[63:0];
            rest_in = sum_ff; root_in = '0; bit_in = 64'd1 << 62;
            mul_en = 1'b1; mul_a = 33'(rd_ff); mul_b = GAIN_Q28;
            state_in = S_SQH;
         end
         S_SQH: begin
            yd_in = prod_ff[63:0];
            rest_in = sq_rest_nx; root_in = sq_root_nx; bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) state_in = S_RNDH;
         end
         S_RNDH: begin
            rhlen_in = root_ff[31:0] + {31'd0, (rest_ff > root_ff)};
            rest_in = full_ff; root_in = '0; bit_in = 64'd1 << 62;
            state_in = S_SQF;
         end
         S_SQF: begin
            rest_in = sq_rest_nx; root_in = sq_root_nx; bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) state_in = S_RNDF;
         end
         S_RNDF: begin
            rlen_in = root_ff[31:0] + {31'd0, (rest_ff > root_ff)};
            pass_in = 1'b0;
            state_in = (rfix_ff == FIX_RTK) ? S_CINIT : S_EMIT;
         end
         S_CINIT: begin
            step_in = '0;
            cx_in = ld_x; cy_in = ld_y; cz_in = '0;
            if (ld_x == 64'sd0 && ld_y == 64'sd0) begin
               state_in = S_CONV;
            end else begin
               if (ld_x < 64'sd0) begin
                  cx_in = -ld_x; cy_in = -ld_y; cz_in = 32'h80000000;
               end
               state_in = S_CITER;
            end
         end
         S_CITER: begin
            if (cy_ff >= 64'sd0) begin
               cx_in = cx_ff + sh_y; cy_in = cy_ff - sh_x;
               cz_in = cz_ff + turn_atan(step_ff);
            end else begin
               cx_in = cx_ff - sh_y; cy_in = cy_ff + sh_x;
               cz_in = cz_ff - turn_atan(step_ff);
            end
            step_in = step_ff + 6'd1;
            if (step_ff == CORDIC_LAST) state_in = S_CONV;
         end
         S_CONV: begin
            mul_en = 1'b1;
            mul_a = pass_ff ? 33'(signed'(cz_ff)) : signed'({1'b0, cz_ff});
            mul_b = CENTI_TURN;
            state_in = S_CFIN;
         end
         S_CFIN: begin
            if (!pass_ff) begin
               rhead_in = h_sum[15:0];
               pass_in = 1'b1;
               state_in = S_CINIT;
            end else begin
               rdip_in = d_sum[15:0];
               rok_in = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!match) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'd0, rok_ff, rdip_ff, rhead_ff, rhlen_ff, rlen_ff,
                              rverr_ff, rherr_ff, rd_ff, re_ff, rn_ff,
                              rsats_ff, rfix_ff};
               rfix_in = '0; rsats_in = '0;
               rn_in = '0; re_in = '0; rd_in = '0;
               rherr_in = '0; rverr_in = '0; rlen_in = '0; rhlen_in = '0;
               rhead_in = '0; rdip_in = '0; rok_in = 1'b0;
               tv_in = 1'b0; bv_in = 1'b0; tval_in = '0; bval_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      prod_in = mul_en ? mul_a * mul_b : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pair_ff <= 1'b1; hofs_ff <= '0; dofs_ff <= '0;
         tv_ff <= 1'b0; bv_ff <= 1'b0; tval_ff <= '0; bval_ff <= '0;
         rfix_ff <= '0; rsats_ff <= '0;
         rn_ff <= '0; re_ff <= '0; rd_ff <= '0;
         rherr_ff <= '0; rverr_ff <= '0; rlen_ff <= '0; rhlen_ff <= '0;
         rhead_ff <= '0; rdip_ff <= '0; rok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pair_ff <= pair_in; hofs_ff <= hofs_in; dofs_ff <= dofs_in;
         tv_ff <= tv_in; bv_ff <= bv_in; tval_ff <= tval_in; bval_ff <= bval_in;
         rfix_ff <= rfix_in; rsats_ff <= rsats_in;
         rn_ff <= rn_in; re_ff <= re_in; rd_ff <= rd_in;
         rherr_ff <= rherr_in; rverr_ff <= rverr_in;
         rlen_ff <= rlen_in; rhlen_ff <= rhlen_in;
         rhead_ff <= rhead_in; rdip_ff <= rdip_in; rok_ff <= rok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in; full_ff <= full_in;
      rest_ff <= rest_in; root_ff <= root_in; bit_ff <= bit_in;
      yd_ff <= yd_in; cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      step_ff <= step_in; pass_ff <= pass_in;
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[218:203] < 16'd36000))
      else $error("heading out of range");
   a_dip_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff[234:219]) <= 16'sd27000 &&
                        $signed(rsp_data_ff[234:219]) >= -16'sd27000))
      else $error("dip out of range");
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && match && (!rsp_valid_ff || rsp_tready)) |=>
      (!tv_ff && !bv_ff && !rok_ff)) else $error("record not cleared");

endmodule

@@ tb/sv/bhdp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhdp_checker
// Watches the item, result and register channels of the baseline heading /
// dip block. It predicts each emitted record and compares it field by field.
// ----------------------------------------------------------------------------
module bhdp_checker
   import bhdp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [239:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [16:0]  csr_data,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic        ok;
      logic [15:0] dip;
      logic [15:0] heading;
      logic [31:0] hlen;
      logic [31:0] len;
      logic [15:0] verr;
      logic [15:0] herr;
      logic [31:0] down;
      logic [31:0] east;
      logic [31:0] north;
      logic [7:0]  sats;
      logic [2:0]  fix;
   } record_t;

   localparam longint COMP_SCALE = 64'sd268435456;
   localparam longint GAIN       = 64'sd442048841;

   logic          pair_on;
   longint        head_ofs, dip_ofs;
   record_t       held;
   logic          time_ok, base_ok;
   logic [29:0]   time_ms, base_ms;
   record_t       expected_records [$];

   function automatic longint unsigned sqrt_rounded(input longint unsigned s);
      longint unsigned rest, res, b;
      rest = s; res = 0; b = 64'd1 << 62;
      while (b > rest) b = b >> 2;
      while (b != 0) begin
         if (rest >= res + b) begin
            rest = rest - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      if (s - res * res > res) res++;
      return res;
   endfunction

   function automatic logic [31:0] vector_turn(inout longint x, inout longint y);
      longint nx, ny;
      logic [31:0] z;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_USED; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + turn_atan(6'(i));
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - turn_atan(6'(i));
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   task automatic compute_orientation();
      longint x, y, yd, h, zs, dv;
      logic [31:0] z;
      longint unsigned zu;
      x = longint'($signed(held.north)) * COMP_SCALE;
      y = longint'($signed(held.east)) * COMP_SCALE;
      z = vector_turn(x, y);
      zu = z;
      h = longint'((zu * 36000 + 64'h8000_0000) >> 32);
      if (h >= 36000) h = 0;   // rounding up to a full turn
      h = h + head_ofs;
      while (h < 0) h += 36000;
      while (h >= 36000) h -= 36000;
      held.heading = h[15:0];
      yd = longint'($signed(held.down)) * GAIN;
      z = vector_turn(x, yd);
      zs = longint'($signed(z));
      dv = ((zs * 36000 + 64'sd2147483648) >>> 32) + dip_ofs;
      if (dv > 27000) dv = 27000;
      if (dv < -27000) dv = -27000;
      held.dip = dv[15:0];
      held.ok = 1'b1;
   endtask

   task automatic predict_item(input logic mode, input logic [175:0] d);
      longint n, e, dn;
      longint unsigned sh;
      if (mode == MODE_TIME) begin
         if (!pair_on) return;
         time_ok = 1'b1;
         time_ms = d[29:0];
      end else begin
         held.fix = d[32:30];
         if (d[32:30] != FIX_INVALID) begin
            held.sats  = d[40:33];
            held.north = d[72:41];
            held.east  = d[104:73];
            held.down  = d[136:105];
            held.herr  = d[152:137];
            held.verr  = d[168:153];
            n = longint'($signed(d[72:41]));
            e = longint'($signed(d[104:73]));
            dn = longint'($signed(d[136:105]));
            sh = longint'(n * n) + longint'(e * e);
            held.hlen = 32'(sqrt_rounded(sh));
            held.len  = 32'(sqrt_rounded(sh + longint'(dn * dn)));
            if (d[32:30] == FIX_RTK) compute_orientation();
         end
         base_ok = 1'b1;
         base_ms = d[29:0];
      end
      if (pair_on && !(time_ok && base_ok && time_ms == base_ms)) return;
      expected_records.push_back(held);
      held = '0;
      time_ok = 0; base_ok = 0; time_ms = 0; base_ms = 0;
   endtask

   task automatic compare_record(input record_t got);
      record_t want;
      if (expected_records.size() == 0) begin
         note_mismatch("unexpected result", 1, 0);
         return;
      end
      want = expected_records.pop_front();
      if (got.fix != want.fix) note_mismatch("fix", got.fix, want.fix);
      if (got.sats != want.sats) note_mismatch("sats", got.sats, want.sats);
      if (got.north != want.north)
         note_mismatch("north", $signed(got.north), $signed(want.north));
      if (got.east != want.east)
         note_mismatch("east", $signed(got.east), $signed(want.east));
      if (got.down != want.down)
         note_mismatch("down", $signed(got.down), $signed(want.down));
      if (got.herr != want.herr) note_mismatch("horiz_err", got.herr, want.herr);
      if (got.verr != want.verr) note_mismatch("vert_err", got.verr, want.verr);
      if (got.len != want.len) note_mismatch("length", got.len, want.len);
      if (got.hlen != want.hlen) note_mismatch("horiz_length", got.hlen, want.hlen);
      if (got.heading != want.heading) note_mismatch("heading", got.heading, want.heading);
      if (got.dip != want.dip)
         note_mismatch("dip", $signed(got.dip), $signed(want.dip));
      if (got.ok != want.ok) note_mismatch("orientation_ok", got.ok, want.ok);
   endtask

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      if (reset) begin
         pair_on = 1'b1; head_ofs = 0; dip_ofs = 0;
         held = '0;
         time_ok = 0; base_ok = 0; time_ms = 0; base_ms = 0;
         expected_records.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PAIR:     pair_on = csr_data[0];
               REG_HEAD_OFS: head_ofs = longint'($signed(csr_data));
               REG_DIP_OFS:  dip_ofs = longint'($signed(csr_data[15:0]));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) compare_record(record_t'(rsp_tdata[235:0]));
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
      end
      pending = expected_records.size();
   end

endmodule

@@ tb/sv/tb_baseline_heading_dip_pairing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_baseline_heading_dip_pairing
// Drives time and baseline items and register writes into the block, with
// random stalls on both sides; the checker predicts and compares records.
// ----------------------------------------------------------------------------
module tb_baseline_heading_dip_pairing;
   import bhdp_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid, req_tready;
   logic [175:0] req_tdata;   // week_ms, fix_kind, sat_count, north, east, down,
                              // horiz_acc, vert_acc (low bit up), zero pad
   logic         req_tuser;   // mode
   logic         rsp_tvalid, rsp_tready;
   logic [239:0] rsp_tdata;   // fix, sats, north, east, down, herr, verr, length,
                              // horiz_length, heading, dip, orientation_ok
   logic         csr_valid, csr_ready;
   logic [1:0]   csr_index;
   logic [16:0]  csr_data;
   int           fail_count, pending;
   logic         calm;        // no idling on either side
   logic         gaps_on;

   baseline_heading_dip_pairing dut (.*);

   bhdp_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // generous wall: ~550 items at worst latency plus stalls, many times over
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // result side: random stall bursts unless calm
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // called at a falling edge; leaves the caller at a falling edge
   task automatic sender_gap();
      if (gaps_on && !calm && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   task automatic send_item(input logic mode, input logic [29:0] ms, input logic [2:0] fix,
                            input logic [7:0] sats, input logic [31:0] n,
                            input logic [31:0] e, input logic [31:0] d,
                            input logic [15:0] ha, input logic [15:0] va);
      sender_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, va, ha, d, e, n, sats, fix, ms};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      // items without a result may still be in flight
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [29:0] rand_ms();
      return ($urandom_range(0, 3) == 0) ? 30'($urandom_range(536870912, 604799999))
                                         : 30'($urandom_range(0, 604799999));
   endfunction

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20000)) - 10000);
         2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         default: return 32'h0;
      endcase
   endfunction

   function automatic logic [2:0] rand_fix();
      // fixed RTK most often to exercise the angle passes
      return ($urandom_range(0, 1) == 0) ? FIX_RTK : 3'($urandom_range(0, 7));
   endfunction

   task automatic send_baseline(input logic [29:0] ms, input logic [2:0] fix);
      send_item(1'b1, ms, fix, 8'($urandom), rand_comp(), rand_comp(), rand_comp(),
                16'($urandom), 16'($urandom));
   endtask

   task automatic send_time(input logic [29:0] ms);
      send_item(MODE_TIME, ms, 3'($urandom), 8'($urandom), $urandom, $urandom, $urandom,
                16'($urandom), 16'($urandom));
   endtask

   // mostly matched time/baseline pairs, some noise and broken pairs
   task automatic random_phase(input int count, input logic hold_off);
      logic [29:0] ms;
      int sent;
      sent = 0;
      while (sent < count) begin
         ms = rand_ms();
         case ($urandom_range(0, 9))
            0: begin send_baseline(ms, rand_fix()); sent++; end
            1: begin send_time(ms); sent++; end
            2: begin send_time(ms); send_baseline(ms ^ 30'd1, rand_fix()); sent += 2; end
            3: begin send_baseline(ms, rand_fix()); send_time(ms); sent += 2; end
            default: begin send_time(ms); send_baseline(ms, rand_fix()); sent += 2; end
         endcase
         if (hold_off) begin
            req_tvalid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      gaps_on = 1'b1;
      req_tvalid = 1'b0; req_tuser = 1'b0; req_tdata = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, pairing on, offsets zero (reset values)
      send_time(30'd5);
      send_item(1'b1, 30'd5, FIX_RTK, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0); // zero vector
      send_time(30'd604799999);
      send_item(1'b1, 30'd604799999, FIX_RTK, 8'hff, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 16'hffff, 16'hffff);
      send_item(1'b1, 30'd7, FIX_RTK, 8'd12, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 16'd1, 16'd2);
      send_time(30'd7);
      // heading just below a full turn rounds to 36000 and folds to 0
      send_time(30'd9);
      send_item(1'b1, 30'd9, FIX_RTK, 8'd9, 32'd100000000, 32'hffff_ffff, 32'd5, 16'd3,
                16'd4);
      // invalid fix keeps the record but still takes the stamp
      send_item(1'b1, 30'd11, 3'd2, 8'd20, 32'd3000, 32'd4000, 32'd1200, 16'd8, 16'd9);
      send_item(1'b1, 30'd11, FIX_INVALID, 8'd33, 32'd1, 32'd1, 32'd1, 16'd1, 16'd1);
      send_time(30'd11);
      // no match, then the time stamp is replaced and matched
      send_time(30'd20);
      send_item(1'b1, 30'd21, FIX_RTK, 8'd5, 32'hffff_fc18, 32'd0, 32'd0, 16'd5, 16'd5);
      send_time(30'd21);
      send_item(1'b1, 30'd0, FIX_RTK, 8'd5, 32'd0, 32'd0, 32'd999, 16'd5, 16'd5);
      send_time(30'd0);
      drain();

      // pairing off, largest offsets: every baseline emits, time ignored
      write_reg(REG_PAIR, 17'd0);
      write_reg(REG_HEAD_OFS, 17'd35999);
      write_reg(REG_DIP_OFS, 17'(16'sd18000));
      send_time(30'd3);
      send_item(1'b1, 30'd1, FIX_RTK, 8'd1, 32'd1000, 32'd1000, 32'h8000_0000, 16'd0,
                16'd0);
      send_item(1'b1, 30'd2, FIX_RTK, 8'd1, 32'd0, 32'hffff_ff00, 32'd0, 16'd0, 16'd0);
      random_phase(100, 1'b0);
      drain();

      // pairing on, most negative offsets
      write_reg(REG_PAIR, 17'd1);
      write_reg(REG_HEAD_OFS, 17'(-17'sd35999));
      write_reg(REG_DIP_OFS, 17'(-16'sd18000));
      random_phase(110, 1'b0);
      drain();

      // sender holds off until each record has been seen
      write_reg(REG_HEAD_OFS, 17'd12345);
      write_reg(REG_DIP_OFS, 17'(-16'sd500));
      random_phase(40, 1'b1);
      drain();

      write_reg(REG_PAIR, 17'd0);
      write_reg(REG_HEAD_OFS, 17'($urandom_range(0, 71998)) - 17'd35999);
      write_reg(REG_DIP_OFS, 17'(16'($urandom_range(0, 36000)) - 16'd18000));
      random_phase(110, 1'b0);
      drain();

      // final stretch: no idling on either side
      write_reg(REG_PAIR, 17'd1);
      write_reg(REG_HEAD_OFS, 17'd0);
      write_reg(REG_DIP_OFS, 17'd0);
      calm = 1'b1;
      random_phase(170, 1'b0);
      drain();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
